// File: rtl/avsn_pkg.sv
`timescale 1ns / 1ps
// avsn_pkg: types and constants for the accelerometer vote speed nudge block
// no dependencies; imported by accel_vote_speed_nudge_top
package avsn_pkg;

  // result kinds carried on the result tuser
  typedef enum logic [2:0] {
    OUT_ROUGH   = 3'd0,
    OUT_TURN    = 3'd1,
    OUT_COUNTED = 3'd2,
    OUT_FASTER  = 3'd3,
    OUT_SLOWER  = 3'd4,
    OUT_TIE     = 3'd5
  } outcome_t;

  // configuration register indexes
  localparam logic [2:0] CFG_VIB_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_YAW_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_GAIN        = 3'd2;
  localparam logic [2:0] CFG_NEUTRAL     = 3'd3;
  localparam logic [2:0] CFG_VOTES       = 3'd4;
  localparam logic [2:0] CFG_NUDGE_STEP  = 3'd5;
  localparam logic [2:0] CFG_UNC_UNANIM  = 3'd6;
  localparam logic [2:0] CFG_UNC_SPLIT   = 3'd7;

  // register reset values
  localparam logic [15:0] RST_VIB_LIMIT  = 16'd3277;
  localparam logic [14:0] RST_YAW_LIMIT  = 15'd3930;
  localparam logic [8:0]  RST_GAIN       = 9'd26;
  localparam logic [14:0] RST_NEUTRAL    = 15'd82;
  localparam logic [7:0]  RST_VOTES      = 8'd10;
  localparam logic [15:0] RST_NUDGE_STEP = 16'd100;
  localparam logic [15:0] RST_UNC_UNANIM = 16'd100;
  localparam logic [15:0] RST_UNC_SPLIT  = 16'd400;

  // fixed point scales
  localparam logic signed [16:0] ONE_G    = 17'sd16384;
  localparam logic [8:0]         GAIN_ONE = 9'd256;
  localparam int unsigned        FULL_TURN = 36000;

  // pitch quantizer: power-of-two phase steps
  localparam int unsigned SINE_IDX_BITS = 10;
  localparam int unsigned NUM_BITS      = 16 + SINE_IDX_BITS;
  // floor(n / FULL_TURN) as (n * RECIP_M) >> RECIP_SHIFT, exact for n < 2^NUM_BITS
  localparam int unsigned RECIP_SHIFT   = NUM_BITS + 16;
  localparam longint unsigned RECIP_M_L =
    ((64'd1 << RECIP_SHIFT) + FULL_TURN - 1) / FULL_TURN;
  localparam logic [26:0] RECIP_M       = 27'(RECIP_M_L);

  // quarter-wave sine polynomial, Q14
  localparam logic [14:0] Q14_ONE  = 15'd16384;
  localparam logic [13:0] Q14_HALF = 14'd8192;
  localparam logic [10:0] SIN_C1   = 11'd1160;
  localparam logic [13:0] SIN_C2   = 14'd10512;
  localparam logic [14:0] SIN_C3   = 15'd25736;

  // item fields that ride along the sine pipeline
  typedef struct packed {
    logic [15:0]        speed;
    logic               rough;
    logic               turn;
    logic signed [23:0] gax;
  } carry_t;

endpackage

// File: rtl/accel_vote_speed_nudge_top.sv
`timescale 1ns / 1ps
// accel_vote_speed_nudge_top: imu sample screening, x-accel filter, vote and speed nudge
// depends on avsn_pkg
// an accepted word passes the input register, five stages of the pitch sine chain,
// the filter/vote stage and the output register before it shows on out_tvalid
// throughput: one word per cycle; each stage holds only when the stage after it is full
// and stalled, so empty stages fill while a finished result waits on out_tready
// reset: synchronous, active low; clears all valid flags, the filter and vote counters,
// and loads every configuration register with its default
module accel_vote_speed_nudge_top
  import avsn_pkg::*;
#(
  parameter int VOTE_COUNTER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // accel_x, accel_z, yaw_rate, pitch_angle, speed_estimate
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // suggested_speed, uncertainty, speed_saturated, zero pad
  output logic [2:0]  out_tuser,  // outcome
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [VOTE_COUNTER_BITS-1:0] VOTE_MAX = '1;

  // configuration registers
  logic [15:0] vib_limit_r;
  logic [14:0] yaw_limit_r;
  logic [8:0]  gain_r;
  logic [14:0] neutral_r;
  logic [7:0]  votes_r;
  logic [15:0] step_r;
  logic [15:0] unc_unanim_r;
  logic [15:0] unc_split_r;

  // running state
  logic signed [23:0]           smoothed_r;
  logic [7:0]                   samples_r;
  logic [VOTE_COUNTER_BITS-1:0] up_r;
  logic [VOTE_COUNTER_BITS-1:0] down_r;

  // stage valids (0 = input register, 6 = filter/vote stage) and per-stage ready
  logic [6:0] v_r;
  logic [7:0] rdy;
  logic       out_valid_r;
  logic       fire6;

  // stage 0: raw sample
  logic signed [15:0] ax0_r;
  logic signed [15:0] az0_r;
  logic signed [15:0] yaw0_r;
  logic signed [15:0] pitch0_r;
  logic [15:0]        speed0_r;

  // sine pipeline payload
  carry_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [SINE_IDX_BITS-1:0] idx1_r;
  logic [14:0]        a2_r, a3_r, a4_r;
  logic               neg2_r, neg3_r, neg4_r, neg5_r;
  logic [28:0]        aa2_r;
  logic [14:0]        u2_3_r;
  logic [24:0]        m3_r;
  logic [27:0]        m4_r;
  logic [28:0]        m5_r;
  logic signed [15:0] sine6_r;

  // output register
  outcome_t    out_outcome_r;
  logic [15:0] out_speed_r;
  logic [15:0] out_unc_r;
  logic        out_sat_r;

  // next values
  carry_t                   c1_nxt;
  logic [SINE_IDX_BITS-1:0] idx_nxt;
  logic [14:0]              a_nxt;
  logic                     neg_nxt;
  logic [28:0]              aa_nxt;
  logic [14:0]              u2_nxt;
  logic [24:0]              m3_nxt;
  logic [27:0]              m4_nxt;
  logic [28:0]              m5_nxt;
  logic signed [15:0]       sine_nxt;
  logic signed [23:0]       smoothed_nxt;
  logic [7:0]               samples_nxt;
  logic [VOTE_COUNTER_BITS-1:0] up_nxt;
  logic [VOTE_COUNTER_BITS-1:0] down_nxt;
  outcome_t                 outcome_nxt;
  logic [15:0]              sugg_nxt;
  logic [15:0]              unc_nxt;
  logic                     sat_nxt;
  logic                     round_close;

  logic [8:0] gain_eff;

  // weight of the new sample, values above 1.0 act as 1.0
  assign gain_eff = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;

  // ready ripples back from the output register; a stage loads when it is empty
  // or its word moves on in the same cycle
  always_comb begin
    rdy[7] = !out_valid_r || out_tready;
    for (int i = 6; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready  = rdy[0];
  assign fire6      = v_r[6] && rdy[7];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_sat_r, out_unc_r, out_speed_r};
  assign out_tuser  = out_outcome_r;

  // stage 0 -> 1: screening, gain product, pitch to phase index
  always_comb begin
    logic signed [16:0] vib_s;
    logic [16:0]        vib_mag;
    logic signed [16:0] yaw_s;
    logic [16:0]        yaw_mag;
    logic [16:0]        pm17;
    logic [NUM_BITS-1:0] num;
    logic [52:0]        qprod;
    vib_s   = $signed({az0_r[15], az0_r}) - ONE_G;
    vib_mag = vib_s[16] ? 17'(-vib_s) : 17'(vib_s);
    yaw_s   = $signed({yaw0_r[15], yaw0_r});
    yaw_mag = yaw_s[16] ? 17'(-yaw_s) : 17'(yaw_s);
    c1_nxt.speed = speed0_r;
    c1_nxt.rough = vib_mag > {1'b0, vib_limit_r};
    c1_nxt.turn  = !c1_nxt.rough && (yaw_mag > {2'b00, yaw_limit_r});
    c1_nxt.gax   = 24'($signed({1'b0, gain_eff}) * ax0_r);
    // pitch into 0..35999, then nearest phase step
    pm17  = {pitch0_r[15], pitch0_r} + (pitch0_r[15] ? 17'(FULL_TURN) : 17'd0);
    num   = {pm17[15:0], {SINE_IDX_BITS{1'b0}}} + NUM_BITS'(FULL_TURN / 2);
    qprod = num * RECIP_M;
    idx_nxt = qprod[RECIP_SHIFT +: SINE_IDX_BITS];
  end

  // stage 1 -> 2: quadrant fold and u squared
  always_comb begin
    logic [1:0]  quad;
    logic [13:0] u;
    quad    = idx1_r[SINE_IDX_BITS-1 -: 2];
    u       = {idx1_r[SINE_IDX_BITS-3:0], {(16 - SINE_IDX_BITS){1'b0}}};
    a_nxt   = quad[0] ? 15'(Q14_ONE - {1'b0, u}) : {1'b0, u};
    neg_nxt = quad[1];
    aa_nxt  = a_nxt * a_nxt;
  end

  // stages 2 -> 6: odd polynomial, rounded after each product
  always_comb begin
    logic [29:0] aa_rnd;
    logic [25:0] m3_rnd;
    logic [13:0] t1;
    logic [28:0] m4_rnd;
    logic [14:0] t2;
    logic [29:0] m5_rnd;
    logic [14:0] t3;
    logic [14:0] mag;
    aa_rnd   = 30'(aa2_r) + 30'(Q14_HALF);
    u2_nxt   = aa_rnd[28:14];
    m3_nxt   = u2_nxt * SIN_C1;
    m3_rnd   = 26'(m3_r) + 26'(Q14_HALF);
    t1       = SIN_C2 - {3'd0, m3_rnd[24:14]};
    m4_nxt   = t1 * u2_3_r;
    m4_rnd   = 29'(m4_r) + 29'(Q14_HALF);
    t2       = SIN_C3 - {1'b0, m4_rnd[27:14]};
    m5_nxt   = t2 * a4_r;
    m5_rnd   = 30'(m5_r) + 30'(Q14_HALF);
    t3       = m5_rnd[28:14];
    mag      = (t3 > Q14_ONE) ? Q14_ONE : t3;
    sine_nxt = neg5_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // stage 6 -> output: filter, vote, round decision
  always_comb begin
    logic [8:0]         wgt;
    logic signed [33:0] fprod;
    logic signed [33:0] facc;
    logic signed [24:0] lin;
    logic signed [24:0] band;
    logic               vote_up;
    logic               vote_dn;
    logic [7:0]         cnt_inc;
    logic [VOTE_COUNTER_BITS-1:0] up_inc;
    logic [VOTE_COUNTER_BITS-1:0] dn_inc;
    logic [16:0]        sum;
    wgt     = GAIN_ONE - gain_eff;
    fprod   = $signed({1'b0, wgt}) * smoothed_r;
    facc    = $signed({{2{c6_r.gax[23]}}, c6_r.gax, 8'd0}) + fprod + 34'sd128;
    smoothed_nxt = facc[31:8];
    lin     = $signed({smoothed_nxt[23], smoothed_nxt}) + $signed({sine6_r, 8'd0});
    band    = $signed({2'b00, neutral_r, 8'd0});
    vote_up = lin > band;
    vote_dn = !vote_up && (lin < -band);
    cnt_inc = (samples_r == 8'hFF) ? samples_r : samples_r + 8'd1;
    up_inc  = (vote_up && up_r != VOTE_MAX) ? up_r + 1'b1 : up_r;
    dn_inc  = (vote_dn && down_r != VOTE_MAX) ? down_r + 1'b1 : down_r;
    round_close = !(cnt_inc < votes_r);
    sum     = {1'b0, c6_r.speed} + {1'b0, step_r};

    sugg_nxt = '0;
    unc_nxt  = '0;
    sat_nxt  = 1'b0;
    if (c6_r.rough) begin
      outcome_nxt = OUT_ROUGH;
    end else if (c6_r.turn) begin
      outcome_nxt = OUT_TURN;
    end else if (!round_close) begin
      outcome_nxt = OUT_COUNTED;
    end else if (up_inc == dn_inc) begin
      outcome_nxt = OUT_TIE;
    end else begin
      unc_nxt = (up_inc == '0 || dn_inc == '0) ? unc_unanim_r : unc_split_r;
      if (up_inc > dn_inc) begin
        outcome_nxt = OUT_FASTER;
        sat_nxt     = sum[16];
        sugg_nxt    = sum[16] ? 16'hFFFF : sum[15:0];
      end else begin
        outcome_nxt = OUT_SLOWER;
        sat_nxt     = step_r > c6_r.speed;
        sugg_nxt    = sat_nxt ? 16'd0 : c6_r.speed - step_r;
      end
    end

    if (round_close) begin
      samples_nxt = '0;
      up_nxt      = '0;
      down_nxt    = '0;
    end else begin
      samples_nxt = cnt_inc;
      up_nxt      = up_inc;
      down_nxt    = dn_inc;
    end
  end

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      smoothed_r   <= '0;
      samples_r    <= '0;
      up_r         <= '0;
      down_r       <= '0;
      vib_limit_r  <= RST_VIB_LIMIT;
      yaw_limit_r  <= RST_YAW_LIMIT;
      gain_r       <= RST_GAIN;
      neutral_r    <= RST_NEUTRAL;
      votes_r      <= RST_VOTES;
      step_r       <= RST_NUDGE_STEP;
      unc_unanim_r <= RST_UNC_UNANIM;
      unc_split_r  <= RST_UNC_SPLIT;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < 7; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (rdy[7]) begin
        out_valid_r <= v_r[6];
      end
      // discarded samples leave the filter and counters alone
      if (fire6 && !c6_r.rough && !c6_r.turn) begin
        smoothed_r <= smoothed_nxt;
        samples_r  <= samples_nxt;
        up_r       <= up_nxt;
        down_r     <= down_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_VIB_LIMIT:  vib_limit_r  <= cfg_wdata;
          CFG_YAW_LIMIT:  yaw_limit_r  <= cfg_wdata[14:0];
          CFG_GAIN:       gain_r       <= cfg_wdata[8:0];
          CFG_NEUTRAL:    neutral_r    <= cfg_wdata[14:0];
          CFG_VOTES:      votes_r      <= cfg_wdata[7:0];
          CFG_NUDGE_STEP: step_r       <= cfg_wdata;
          CFG_UNC_UNANIM: unc_unanim_r <= cfg_wdata;
          CFG_UNC_SPLIT:  unc_split_r  <= cfg_wdata;
        endcase
      end
    end
  end

  // pipeline payload, no reset
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ax0_r    <= in_tdata[15:0];
      az0_r    <= in_tdata[31:16];
      yaw0_r   <= in_tdata[47:32];
      pitch0_r <= in_tdata[63:48];
      speed0_r <= in_tdata[79:64];
    end
    if (rdy[1]) begin
      c1_r   <= c1_nxt;
      idx1_r <= idx_nxt;
    end
    if (rdy[2]) begin
      c2_r   <= c1_r;
      a2_r   <= a_nxt;
      neg2_r <= neg_nxt;
      aa2_r  <= aa_nxt;
    end
    if (rdy[3]) begin
      c3_r   <= c2_r;
      a3_r   <= a2_r;
      neg3_r <= neg2_r;
      u2_3_r <= u2_nxt;
      m3_r   <= m3_nxt;
    end
    if (rdy[4]) begin
      c4_r   <= c3_r;
      a4_r   <= a3_r;
      neg4_r <= neg3_r;
      m4_r   <= m4_nxt;
    end
    if (rdy[5]) begin
      c5_r   <= c4_r;
      neg5_r <= neg4_r;
      m5_r   <= m5_nxt;
    end
    if (rdy[6]) begin
      c6_r    <= c5_r;
      sine6_r <= sine_nxt;
    end
    if (rdy[7]) begin
      out_outcome_r <= outcome_nxt;
      out_speed_r   <= sugg_nxt;
      out_unc_r     <= unc_nxt;
      out_sat_r     <= sat_nxt;
    end
  end

`ifndef SYNTHESIS
  // only a speed nudge carries a payload
  a_quiet_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !(out_tuser == OUT_FASTER || out_tuser == OUT_SLOWER)
    |-> out_tdata == '0)
    else $error("payload set on a result without a nudge");

  // a closed round clears all counters
  a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire6 && !c6_r.rough && !c6_r.turn && round_close
    |=> samples_r == '0 && up_r == '0 && down_r == '0)
    else $error("counters not cleared after a decision");

  // a discarded sample leaves the filter alone
  a_discard_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire6 && (c6_r.rough || c6_r.turn) |=> $stable(smoothed_r))
    else $error("filter moved on a discarded sample");

  // directional votes never outnumber counted samples
  a_vote_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(up_r) + int'(down_r) <= int'(samples_r))
    else $error("vote counters exceed sample count");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for accel_vote_speed_nudge_top, streams imu sample words with
// random idling on both sides and checks every result word against an in-bench model
// depends on avsn_pkg and rtl/accel_vote_speed_nudge_top.sv
module tb;
  import avsn_pkg::*;

  // pitch quantizer size and counter ceilings of the block as built
  localparam int PHASE_STEPS   = 1024;
  localparam int VOTE_CAP      = 255;
  localparam int SAMPLE_CAP    = 255;
  localparam int NUM_REGS      = 8;
  // pipeline latency plus margin before touching registers or ending
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PRINT_LIMIT   = 30;

  // one expected result word
  typedef struct packed {
    outcome_t    kind;
    logic [15:0] speed;
    logic [15:0] unc;
    logic        sat;
  } nudge_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // accel_x, accel_z, yaw_rate, pitch_angle, speed_estimate
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // suggested_speed, uncertainty, speed_saturated, zero pad
  logic [2:0]  out_tuser;  // outcome
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  accel_vote_speed_nudge_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // register file as the block holds it, and the values the next write pass loads
  int setting [NUM_REGS];
  int next_setting [NUM_REGS];

  // filter and vote state mirrored from the block
  int filt_acc;
  int n_counted;
  int n_up;
  int n_down;

  // results owed by the block, oldest first
  nudge_t pending_nudges [$];

  int mismatches;
  int words_sent;
  int words_seen;
  int seen_kind [6];
  int cycle_count;

  // idling controls shared by the sender and the receiver process
  bit sender_gaps;
  bit receiver_stalls;
  int hold_request;

  // shape of the random samples
  int lean_x;
  int spread_x;
  int pitch_span;
  int noise_rate;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard: a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_nudges.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // sin over the first quarter turn, u and result in q14
  function automatic int unsigned quarter_wave(input int unsigned u);
    int unsigned u2;
    int unsigned t;
    u2 = (u * u + 8192) >> 14;
    t = 10512 - ((1160 * u2 + 8192) >> 14);
    t = 25736 - ((t * u2 + 8192) >> 14);
    t = (t * u + 8192) >> 14;
    return (t > 16384) ? 16384 : t;
  endfunction

  // gravity share along x for a pitch in hundredths of a degree, q14 of 1 g
  function automatic int pitch_gravity(input int pitch);
    int          p;
    int unsigned step;
    int unsigned phase;
    int unsigned u;
    int unsigned mag;
    p = pitch % 36000;
    if (p < 0) p += 36000;
    // round to the nearest phase step, then a q16 fraction of the full turn
    step = int'(unsigned'(p * PHASE_STEPS + 18000) / 36000) % PHASE_STEPS;
    phase = step * 65536 / PHASE_STEPS;
    u = phase & 16383;
    mag = phase[14] ? quarter_wave(16384 - u) : quarter_wave(u);
    return phase[15] ? -int'(mag) : int'(mag);
  endfunction

  // screening, filter, vote and round decision for one accepted sample word
  function automatic nudge_t predict_outcome(input logic [79:0] word);
    logic signed [15:0] ax;
    logic signed [15:0] az;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [15:0]        speed;
    int                 vib;
    int                 yaw_mag;
    int                 gain;
    int                 sum;
    longint             acc;
    longint             lin;
    longint             band;
    nudge_t             r;
    ax    = word[15:0];
    az    = word[31:16];
    yaw   = word[47:32];
    pitch = word[63:48];
    speed = word[79:64];
    r.kind  = OUT_ROUGH;
    r.speed = '0;
    r.unc   = '0;
    r.sat   = 1'b0;

    // rough road wins over a turn; discards leave all state alone
    vib = int'(az) - int'(ONE_G);
    if (vib < 0) vib = -vib;
    if (vib > setting[CFG_VIB_LIMIT]) return r;
    yaw_mag = int'(yaw);
    if (yaw_mag < 0) yaw_mag = -yaw_mag;
    if (yaw_mag > setting[CFG_YAW_LIMIT]) begin
      r.kind = OUT_TURN;
      return r;
    end

    // exponential filter in q8, gain above one acts as one, floor after rounding bias
    gain = (setting[CFG_GAIN] > 256) ? 256 : setting[CFG_GAIN];
    acc = longint'(gain) * longint'(ax) * 256 + longint'(256 - gain) * filt_acc + 128;
    filt_acc = int'(acc >>> 8);

    lin  = longint'(filt_acc) + longint'(pitch_gravity(int'(pitch))) * 256;
    band = longint'(setting[CFG_NEUTRAL]) * 256;
    if (lin > band) begin
      if (n_up < VOTE_CAP) n_up++;
    end else if (lin < -band) begin
      if (n_down < VOTE_CAP) n_down++;
    end
    if (n_counted < SAMPLE_CAP) n_counted++;

    if (n_counted < setting[CFG_VOTES]) begin
      r.kind = OUT_COUNTED;
      return r;
    end

    if (n_up == n_down) begin
      r.kind = OUT_TIE;
    end else begin
      r.unc = 16'((n_up == 0 || n_down == 0) ? setting[CFG_UNC_UNANIM]
                                              : setting[CFG_UNC_SPLIT]);
      if (n_up > n_down) begin
        r.kind = OUT_FASTER;
        sum = int'(speed) + setting[CFG_NUDGE_STEP];
        if (sum > 65535) begin
          sum = 65535;
          r.sat = 1'b1;
        end
      end else begin
        r.kind = OUT_SLOWER;
        sum = int'(speed) - setting[CFG_NUDGE_STEP];
        if (sum < 0) begin
          sum = 0;
          r.sat = 1'b1;
        end
      end
      r.speed = 16'(sum);
    end
    n_counted = 0;
    n_up = 0;
    n_down = 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch at result %0d: %s", words_seen, what);
  endtask

  // ---------------------------------------------------------------------------
  // input side: one word, held until the block takes it, then maybe a gap
  // ---------------------------------------------------------------------------
  task automatic send_sample(input int ax, input int az, input int yaw, input int pitch,
                             input int speed);
    logic [79:0] word;
    word = {16'(speed), 16'(pitch), 16'(yaw), 16'(az), 16'(ax)};
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    // the word went in at this edge, predict against registers as they stand
    pending_nudges.push_back(predict_outcome(word));
    words_sent++;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // mostly samples that survive screening; the rest is raw noise on the accel, yaw and pitch fields
  task automatic send_random_sample();
    int ax;
    int az;
    int yaw;
    int pitch;
    int speed;
    int lim;
    case ($urandom_range(0, 9))
      0:       speed = 0;
      1:       speed = 65535;
      default: speed = int'($urandom_range(0, 65535));
    endcase
    if (int'($urandom_range(0, 99)) < noise_rate) begin
      ax    = int'($signed(16'($urandom)));
      az    = int'($signed(16'($urandom)));
      yaw   = int'($signed(16'($urandom)));
      pitch = int'($signed(16'($urandom)));
    end else begin
      az    = clip16(int'(ONE_G) + rand_between(-setting[CFG_VIB_LIMIT],
                                                setting[CFG_VIB_LIMIT]));
      lim   = setting[CFG_YAW_LIMIT];
      yaw   = rand_between(-lim, lim);
      ax    = clip16(lean_x + rand_between(-spread_x, spread_x));
      pitch = rand_between(-pitch_span, pitch_span);
    end
    send_sample(ax, az, yaw, pitch, speed);
  endtask

  // stop offering words and let every owed result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_nudges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // load all registers from next_setting, one write per cycle, block must be idle
  task automatic program_settings();
    logic [15:0] mask;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (3'(i))
        CFG_YAW_LIMIT, CFG_NEUTRAL: mask = 16'h7fff;
        CFG_GAIN:                   mask = 16'h01ff;
        CFG_VOTES:                  mask = 16'h00ff;
        default:                    mask = 16'hffff;
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= 16'(next_setting[i]);
      setting[i] = next_setting[i] & int'(mask);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // random register set, mostly realistic with the odd extreme
  task automatic randomize_settings();
    case ($urandom_range(0, 9))
      0:       next_setting[CFG_VIB_LIMIT] = 0;
      1:       next_setting[CFG_VIB_LIMIT] = 65535;
      default: next_setting[CFG_VIB_LIMIT] = rand_between(500, 20000);
    endcase
    case ($urandom_range(0, 9))
      0:       next_setting[CFG_YAW_LIMIT] = 0;
      1:       next_setting[CFG_YAW_LIMIT] = 32767;
      default: next_setting[CFG_YAW_LIMIT] = rand_between(500, 20000);
    endcase
    case ($urandom_range(0, 7))
      0:       next_setting[CFG_GAIN] = 0;
      1:       next_setting[CFG_GAIN] = 256;
      default: next_setting[CFG_GAIN] = rand_between(1, 255);
    endcase
    case ($urandom_range(0, 7))
      0:       next_setting[CFG_NEUTRAL] = 32767;
      1:       next_setting[CFG_NEUTRAL] = 0;
      default: next_setting[CFG_NEUTRAL] = rand_between(0, 3000);
    endcase
    next_setting[CFG_VOTES] = ($urandom_range(0, 9) == 0) ? rand_between(13, 40)
                                                          : rand_between(1, 12);
    case ($urandom_range(0, 7))
      0:       next_setting[CFG_NUDGE_STEP] = 65535;
      1:       next_setting[CFG_NUDGE_STEP] = 0;
      default: next_setting[CFG_NUDGE_STEP] = rand_between(1, 5000);
    endcase
    next_setting[CFG_UNC_UNANIM] = int'($urandom_range(0, 65535));
    next_setting[CFG_UNC_SPLIT]  = int'($urandom_range(0, 65535));
  endtask

  // ---------------------------------------------------------------------------
  // output side: receiver with random stalls and an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        // long hold-off, counted here so the sender keeps pushing meanwhile
        hold_left = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (hold_left - 1) @(posedge clk);
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // every result word is checked against the oldest expectation
  always @(posedge clk) begin : check_words
    nudge_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (out_tuser <= OUT_TIE) seen_kind[out_tuser]++;
      if (pending_nudges.size() == 0) begin
        report_mismatch("result word with no sample owed");
      end else begin
        want = pending_nudges.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("outcome %0d, want %0d", out_tuser, want.kind));
        if (out_tdata[15:0] !== want.speed)
          report_mismatch($sformatf("suggested speed %0d, want %0d", out_tdata[15:0],
                                    want.speed));
        if (out_tdata[31:16] !== want.unc)
          report_mismatch($sformatf("uncertainty %0d, want %0d", out_tdata[31:16],
                                    want.unc));
        if (out_tdata[32] !== want.sat)
          report_mismatch($sformatf("saturated flag %b, want %b", out_tdata[32], want.sat));
        if (out_tdata[39:33] !== '0)
          report_mismatch($sformatf("pad bits %b not zero", out_tdata[39:33]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: screening boundaries, field extremes, two voting rounds
  task automatic test_directed_defaults();
    // just inside both screening limits
    send_sample(0, 16384, 0, 0, 0);
    send_sample(32767, 16384 + 3277, 3930, 18000, 65535);
    send_sample(-32768, 16384 - 3277, -3930, -18000, 0);
    // one step outside: rough both ways, turn one way
    send_sample(0, 16384 + 3278, 0, 0, 1000);
    send_sample(0, 16384 - 3278, 0, 0, 1000);
    send_sample(0, 16384, 3931, 0, 1000);
    // yaw of the most negative code has no positive twin
    send_sample(0, 16384, -32768, 0, 1000);
    // rough and turn at once reports rough
    send_sample(0, -32768, -32768, 0, 1000);
    send_sample(0, 32767, 0, 0, 0);
    // close the first round with mixed pitch
    send_sample(1000, 16384, 0, 9000, 5000);
    send_sample(-1000, 16384, 0, -9000, 5000);
    send_sample(0, 16384, 0, 100, 5000);
    send_sample(0, 16384, 0, -100, 5000);
    send_sample(20000, 16384, 0, 17999, 5000);
    send_sample(-20000, 16384, 0, -17999, 5000);
    send_sample(0, 16384, 0, 0, 5000);
    // steep uphill for a whole round: unanimous, near the top speed
    repeat (10) send_sample(16384, 16384, 0, 9000, 65500);
    wait_idle();
  endtask

  // each register at its extremes, including gain above one and a zero round length
  task automatic test_register_extremes();
    // zero limits: only a perfectly level, straight sample is counted
    next_setting[CFG_VIB_LIMIT] = 0;
    next_setting[CFG_YAW_LIMIT] = 0;
    next_setting[CFG_VOTES]     = 3;
    program_settings();
    send_sample(100, 16384, 0, 0, 50);
    send_sample(100, 16385, 0, 0, 50);
    send_sample(100, 16383, 0, 0, 50);
    send_sample(100, 16384, 1, 0, 50);
    send_sample(100, 16384, -1, 0, 50);
    send_sample(100, 16384, 0, -9000, 50);
    send_sample(100, 16384, 0, 9000, 50);
    wait_idle();

    // widest limits, frozen filter, every counted sample decides, full-scale nudges
    next_setting[CFG_VIB_LIMIT]  = 65535;
    next_setting[CFG_YAW_LIMIT]  = 32767;
    next_setting[CFG_GAIN]       = 0;
    next_setting[CFG_NEUTRAL]    = 0;
    next_setting[CFG_VOTES]      = 1;
    next_setting[CFG_NUDGE_STEP] = 65535;
    next_setting[CFG_UNC_UNANIM] = 0;
    next_setting[CFG_UNC_SPLIT]  = 65535;
    program_settings();
    send_sample(-32768, -32768, 32767, 9000, 0);
    send_sample(0, 32767, -32767, 9000, 1);
    send_sample(0, 16384, 0, -9000, 65535);
    send_sample(0, 16384, 0, -9000, 65534);
    send_sample(0, 16384, -32768, 9000, 100);
    wait_idle();

    // unity gain and the widest deadband: full-scale accel sits right on the band
    next_setting[CFG_GAIN]       = 256;
    next_setting[CFG_NEUTRAL]    = 32767;
    next_setting[CFG_VOTES]      = 2;
    next_setting[CFG_NUDGE_STEP] = 0;
    program_settings();
    send_sample(32767, 16384, 0, 0, 300);
    send_sample(32767, 16384, 0, 0, 300);
    send_sample(32767, 16384, 0, 100, 300);
    send_sample(-32768, 16384, 0, -100, 300);
    wait_idle();

    // gain above one acts as one; a round length of zero closes on every sample
    next_setting[CFG_GAIN]       = 300;
    next_setting[CFG_NEUTRAL]    = 82;
    next_setting[CFG_VOTES]      = 0;
    next_setting[CFG_NUDGE_STEP] = 250;
    program_settings();
    send_sample(1000, 16384, 0, 0, 500);
    send_sample(-1000, 16384, 0, 0, 500);
    send_sample(0, 16384, 0, 0, 500);
    wait_idle();
    next_setting[CFG_GAIN] = 511;
    program_settings();
    send_sample(5000, 16384, 0, 0, 500);
    send_sample(-5000, 16384, 0, 0, 500);
    wait_idle();
  endtask

  // longest round: every sample votes up so both counters reach their ceiling
  task automatic test_full_round();
    next_setting[CFG_VIB_LIMIT]  = 65535;
    next_setting[CFG_YAW_LIMIT]  = 32767;
    next_setting[CFG_GAIN]       = 128;
    next_setting[CFG_NEUTRAL]    = 0;
    next_setting[CFG_VOTES]      = 255;
    next_setting[CFG_NUDGE_STEP] = 1234;
    next_setting[CFG_UNC_UNANIM] = 7;
    next_setting[CFG_UNC_SPLIT]  = 9;
    program_settings();
    repeat (300) begin
      send_sample(rand_between(1000, 32767), int'($signed(16'($urandom))),
                  rand_between(-32767, 32767), rand_between(500, 17500),
                  int'($urandom_range(0, 65535)));
    end
    wait_idle();
  endtask

  // random register sets, each driven with a random sample profile
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      randomize_settings();
      program_settings();
      lean_x = rand_between(-3000, 3000);
      case ($urandom_range(0, 2))
        0:       spread_x = 100;
        1:       spread_x = 2000;
        default: spread_x = 32767;
      endcase
      case ($urandom_range(0, 3))
        0:       pitch_span = 0;
        1:       pitch_span = 200;
        2:       pitch_span = 3000;
        default: pitch_span = 18000;
      endcase
      noise_rate = rand_between(10, 20);
      // some phases run with one side never idling
      sender_gaps     = (phase != 2);
      receiver_stalls = (phase != 4);
      repeat (170) send_random_sample();
      wait_idle();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // receiver holds off long enough that the pipeline fills and input stalls
  task automatic test_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 300;
    repeat (120) send_random_sample();
    wait_idle();
  endtask

  // tail of the run: no idling on either side, a word every cycle
  task automatic test_steady_stream();
    randomize_settings();
    program_settings();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    pitch_span      = 3000;
    repeat (120) send_random_sample();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_VIB_LIMIT;
    cfg_wdata <= '0;

    // register and state values the block comes out of reset with
    setting[CFG_VIB_LIMIT]  = int'(RST_VIB_LIMIT);
    setting[CFG_YAW_LIMIT]  = int'(RST_YAW_LIMIT);
    setting[CFG_GAIN]       = int'(RST_GAIN);
    setting[CFG_NEUTRAL]    = int'(RST_NEUTRAL);
    setting[CFG_VOTES]      = int'(RST_VOTES);
    setting[CFG_NUDGE_STEP] = int'(RST_NUDGE_STEP);
    setting[CFG_UNC_UNANIM] = int'(RST_UNC_UNANIM);
    setting[CFG_UNC_SPLIT]  = int'(RST_UNC_SPLIT);
    next_setting = setting;
    filt_acc  = 0;
    n_counted = 0;
    n_up      = 0;
    n_down    = 0;

    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_request    = 0;
    lean_x          = 0;
    spread_x        = 2000;
    pitch_span      = 3000;
    noise_rate      = 15;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_full_round();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    if (pending_nudges.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_nudges.size()));
    $display("sent %0d samples: %0d rough, %0d turn, %0d counted without a decision",
             words_sent, seen_kind[OUT_ROUGH], seen_kind[OUT_TURN], seen_kind[OUT_COUNTED]);
    $display("rounds closed: %0d faster, %0d slower, %0d tie; %0d mismatches",
             seen_kind[OUT_FASTER], seen_kind[OUT_SLOWER], seen_kind[OUT_TIE], mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: accel_vote_speed_nudge_top.f
rtl/avsn_pkg.sv
rtl/accel_vote_speed_nudge_top.sv
verif/tb.sv
